// ===== src/mcp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mcp_pkg;

	localparam int COORD_BITS  = 10;
	localparam int OFS_BITS    = COORD_BITS + 1;
	localparam int DEC_BITS    = COORD_BITS + 6;
	localparam int POINT_BITS  = COORD_BITS + 2;
	localparam int GROUP_SIZE  = 8;
	localparam int IDX_BITS    = $clog2(GROUP_SIZE);
	localparam int QUEUE_DEPTH = 2;
	localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

	localparam logic signed [DEC_BITS-1:0] DEC_INIT = DEC_BITS'(5);

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_NEXT  = 1'b1
	} cmd_t;

	// one group of eight mirrored points, offsets taken before the step
	typedef struct packed {
		logic        [COORD_BITS-1:0] cx;
		logic        [COORD_BITS-1:0] cy;
		logic signed [OFS_BITS-1:0]   ox;
		logic signed [OFS_BITS-1:0]   oy;
		logic                         done;
	} group_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

// ===== src/midpoint_circle_points_unit.sv =====
// Midpoint circle rasterizer: eight mirrored points per accepted start item or next item of an active circle.
// Throughput: one point beat per cycle while pop is held and a group is queued;
// the two-entry group queue absorbs short output stalls.
// Path: a taken item goes through the group queue, grp_q and the output register.
// Reset (arst_n low): no circle active, queue and output stage empty.
`timescale 1ns / 1ps
`default_nettype none
module midpoint_circle_points_unit import mcp_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic                         command,
	input  logic [COORD_BITS-1:0]        center_x,
	input  logic [COORD_BITS-1:0]        center_y,
	input  logic [COORD_BITS-1:0]        radius,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [POINT_BITS-1:0] point_x,
	output logic signed [POINT_BITS-1:0] point_y,
	output logic                         group_last,
	output logic                         circle_done
);

	q_stat_t q_stat;
	group_t  q_wdata, q_rdata;
	logic    q_push, q_pop;

	mcp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.command  (command),
		.center_x (center_x),
		.center_y (center_y),
		.radius   (radius),
		.q_stat   (q_stat),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	mcp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.stat    (q_stat)
	);

	mcp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.q_data      (q_rdata),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.point_x     (point_x),
		.point_y     (point_y),
		.group_last  (group_last),
		.circle_done (circle_done)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("group queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("group queue read while empty");

	// all beats of one group carry the same done flag
	a_done_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !group_last) |=> (circle_done == $past(circle_done)))
		else $error("circle_done changed inside a group");

endmodule
`default_nettype wire

// ===== src/mcp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mcp_front import mcp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic                  command,
	input  logic [COORD_BITS-1:0] center_x,
	input  logic [COORD_BITS-1:0] center_y,
	input  logic [COORD_BITS-1:0] radius,
	input  q_stat_t               q_stat,
	output logic                  q_push,
	output group_t                q_data
);

	logic        [COORD_BITS-1:0] ccol_q, crow_q;
	logic signed [OFS_BITS-1:0]   ox_q, oy_q;
	logic signed [DEC_BITS-1:0]   dec_q;
	logic                         active_q;

	logic                         is_start, take, gt, done;
	logic        [COORD_BITS-1:0] cx, cy;
	logic signed [OFS_BITS-1:0]   x0, y0, x1, y1;
	logic signed [DEC_BITS-1:0]   r_ext, d0, d1, d2, x_ext, y_ext;

	always_comb begin
		is_start = (command == CMD_START);
		take     = push && !q_stat.full;
		r_ext    = signed'({{(DEC_BITS-COORD_BITS){1'b0}}, radius});
		cx       = is_start ? center_x : ccol_q;
		cy       = is_start ? center_y : crow_q;
		x0       = is_start ? '0 : ox_q;
		y0       = is_start ? signed'({1'b0, radius}) : oy_q;
		d0       = is_start ? DEC_INIT - (r_ext <<< 2) : dec_q;
		// decision > 0
		gt       = !d0[DEC_BITS-1] && (d0 != '0);
		y1       = gt ? y0 - OFS_BITS'(1) : y0;
		y_ext    = DEC_BITS'(y1);
		d1       = gt ? d0 - (y_ext <<< 3) : d0;
		x1       = x0 + OFS_BITS'(1);
		x_ext    = DEC_BITS'(x1);
		d2       = d1 + (x_ext <<< 3) + DEC_BITS'(4);
		done     = (x1 > y1);
		q_push   = take && (is_start || active_q);
		q_data   = '{cx: cx, cy: cy, ox: x0, oy: y0, done: done};
		full     = q_stat.full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ccol_q   <= '0;
			crow_q   <= '0;
			ox_q     <= '0;
			oy_q     <= '0;
			dec_q    <= '0;
			active_q <= 1'b0;
		end else if (q_push) begin
			ccol_q   <= cx;
			crow_q   <= cy;
			ox_q     <= x1;
			oy_q     <= y1;
			dec_q    <= d2;
			active_q <= !done;
		end
	end

endmodule
`default_nettype wire

// ===== src/mcp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mcp_queue import mcp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  group_t  wr_data,
	input  logic    rd_en,
	output group_t  rd_data,
	output q_stat_t stat
);

	group_t              mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] cnt_q;

	function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
		ptr_inc = (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
	endfunction

	assign rd_data    = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == CNT_BITS'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/mcp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mcp_back import mcp_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  q_stat_t                      q_stat,
	input  group_t                       q_data,
	output logic                         q_pop,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [POINT_BITS-1:0] point_x,
	output logic signed [POINT_BITS-1:0] point_y,
	output logic                         group_last,
	output logic                         circle_done
);

	localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(GROUP_SIZE - 1);

	group_t                       grp_q;
	logic                         busy_q;
	logic [IDX_BITS-1:0]          k_q;
	logic                         ovld_q;
	logic signed [POINT_BITS-1:0] px_q, py_q;
	logic                         last_q, done_q;

	logic                         xfer, load, k_last;
	logic signed [POINT_BITS-1:0] cx_e, cy_e, a_e, b_e, px, py;

	always_comb begin
		k_last = (k_q == LAST_IDX);
		xfer   = busy_q && (!ovld_q || pop);
		load   = !q_stat.empty && (!busy_q || (xfer && k_last));
		q_pop  = load;
		cx_e   = signed'({{(POINT_BITS-COORD_BITS){1'b0}}, grp_q.cx});
		cy_e   = signed'({{(POINT_BITS-COORD_BITS){1'b0}}, grp_q.cy});
		// bit 0 swaps x/y, bit 1 negates the column term, bit 2 the row term
		a_e    = POINT_BITS'(k_q[0] ? grp_q.oy : grp_q.ox);
		b_e    = POINT_BITS'(k_q[0] ? grp_q.ox : grp_q.oy);
		px     = k_q[1] ? cx_e - a_e : cx_e + a_e;
		py     = k_q[2] ? cy_e - b_e : cy_e + b_e;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_q <= q_data;
		end
		if (xfer) begin
			px_q   <= px;
			py_q   <= py;
			last_q <= k_last;
			done_q <= grp_q.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
			ovld_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (xfer && k_last) begin
				busy_q <= 1'b0;
			end else if (xfer) begin
				k_q <= k_q + IDX_BITS'(1);
			end
			if (xfer) begin
				ovld_q <= 1'b1;
			end else if (pop) begin
				ovld_q <= 1'b0;
			end
		end
	end

	assign empty       = !ovld_q;
	assign point_x     = px_q;
	assign point_y     = py_q;
	assign group_last  = last_q;
	assign circle_done = done_q;

endmodule
`default_nettype wire

// ===== tb/midpoint_circle_points_unit_tb.sv =====
`timescale 1ns / 1ps
module midpoint_circle_points_unit_tb;
	import mcp_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 160;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		logic signed [POINT_BITS-1:0] px;
		logic signed [POINT_BITS-1:0] py;
		logic                         group_last;
		logic                         circle_done;
	} point_beat_t;

	class circle_scoreboard;
		point_beat_t           pending[$];
		logic [COORD_BITS-1:0] centre_col;
		logic [COORD_BITS-1:0] centre_row;
		int                    ofs_x;
		int                    ofs_y;
		int                    decision;
		bit                    active;
		int                    errors;
		int                    beats;

		function new();
			centre_col = '0;
			centre_row = '0;
			ofs_x      = 0;
			ofs_y      = 0;
			decision   = 0;
			active     = 1'b0;
			errors     = 0;
			beats      = 0;
		endfunction

		task report_mismatch(string what);
			$display("point beat %0d: %s", beats, what);
			errors++;
		endtask

		// returns the number of point beats the accepted item produces
		function int note_item(cmd_t cmd, logic [COORD_BITS-1:0] cx,
				logic [COORD_BITS-1:0] cy, logic [COORD_BITS-1:0] r);
			int          x0;
			int          y0;
			int          c;
			int          w;
			int          a;
			int          b;
			int          k;
			point_beat_t pt;
			if (cmd == CMD_START) begin
				centre_col = cx;
				centre_row = cy;
				ofs_x      = 0;
				ofs_y      = int'(r);
				decision   = 5 - 4 * int'(r);
				active     = 1'b1;
			end else if (!active) begin
				return 0;
			end
			x0 = ofs_x;
			y0 = ofs_y;
			c  = int'(centre_col);
			w  = int'(centre_row);
			if (decision > 0) begin
				ofs_y--;
				decision -= 8 * ofs_y;
			end
			ofs_x++;
			decision += 8 * ofs_x + 4;
			if (ofs_x > ofs_y)
				active = 1'b0;
			// bit 0 swaps x/y, bit 1 negates the column term, bit 2 the row term
			for (k = 0; k < GROUP_SIZE; k++) begin
				a = k[0] ? y0 : x0;
				b = k[0] ? x0 : y0;
				pt.px          = POINT_BITS'(c + (k[1] ? -a : a));
				pt.py          = POINT_BITS'(w + (k[2] ? -b : b));
				pt.group_last  = (k == GROUP_SIZE - 1);
				pt.circle_done = !active;
				pending.insert(pending.size(), pt);
			end
			return GROUP_SIZE;
		endfunction

		task check_point(logic signed [POINT_BITS-1:0] px, logic signed [POINT_BITS-1:0] py,
				logic gl, logic cd);
			point_beat_t e;
			beats++;
			if (pending.size() == 0) begin
				report_mismatch("point with nothing expected");
				return;
			end
			e = pending.pop_front();
			if (px !== e.px)
				report_mismatch($sformatf("point_x %0d, expected %0d", px, e.px));
			if (py !== e.py)
				report_mismatch($sformatf("point_y %0d, expected %0d", py, e.py));
			if (gl !== e.group_last)
				report_mismatch($sformatf("group_last %b, expected %b", gl, e.group_last));
			if (cd !== e.circle_done)
				report_mismatch($sformatf("circle_done %b, expected %b", cd, e.circle_done));
		endtask
	endclass

	logic                         clk      = 1'b0;
	logic                         arst_n   = 1'b0;
	logic                         push     = 1'b0;
	logic                         full;
	logic                         command  = 1'b0;
	logic [COORD_BITS-1:0]        center_x = '0;
	logic [COORD_BITS-1:0]        center_y = '0;
	logic [COORD_BITS-1:0]        radius   = '0;
	logic                         empty;
	logic                         pop      = 1'b0;
	logic signed [POINT_BITS-1:0] point_x;
	logic signed [POINT_BITS-1:0] point_y;
	logic                         group_last;
	logic                         circle_done;

	circle_scoreboard sb = new();
	int               cycle_count  = 0;
	int               sent_items   = 0;
	bit               push_calm    = 1'b0;
	bit               pop_calm     = 1'b0;

	midpoint_circle_points_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.command     (command),
		.center_x    (center_x),
		.center_y    (center_y),
		.radius      (radius),
		.empty       (empty),
		.pop         (pop),
		.point_x     (point_x),
		.point_y     (point_y),
		.group_last  (group_last),
		.circle_done (circle_done)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("midpoint_circle_points_unit: mismatch");
			$finish;
		end
	end

	// now and then flip into a stretch with no idling at all
	function automatic int draw_gap(inout bit calm);
		if ($urandom_range(0, 19) == 0)
			calm = !calm;
		return calm ? 0 : int'($urandom_range(0, 14));
	endfunction

	task automatic send_item(cmd_t cmd, logic [COORD_BITS-1:0] cx,
			logic [COORD_BITS-1:0] cy, logic [COORD_BITS-1:0] r);
		int gap;
		gap = draw_gap(push_calm);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push     <= 1'b1;
		command  <= cmd;
		center_x <= cx;
		center_y <= cy;
		radius   <= r;
		do @(posedge clk); while (full);
		void'(sb.note_item(cmd, cx, cy, r));
		sent_items++;
	endtask

	// next-beat fields are don't-care, so they carry random bits
	task automatic run_circle(logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
			logic [COORD_BITS-1:0] r, int max_next);
		int n;
		n = 0;
		send_item(CMD_START, cx, cy, r);
		while (sb.active && n < max_next && sent_items < RANDOM_ITEMS) begin
			send_item(CMD_NEXT, COORD_BITS'($urandom), COORD_BITS'($urandom),
				COORD_BITS'($urandom));
			n++;
		end
	endtask

	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_gap(pop_calm);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			sb.check_point(point_x, point_y, group_last, circle_done);
		end
	end

	initial begin
		int sel;
		int max_next;
		logic [COORD_BITS-1:0] r;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle next, zero radius at both corners, full radius off screen,
		// restart mid-circle, tiny circles run out, and idle next after the end
		send_item(CMD_NEXT, '1, '1, '1);
		run_circle('0, '0, '0, 0);
		send_item(CMD_NEXT, '0, '0, '0);
		run_circle('1, '1, '0, 0);
		run_circle('0, '0, '1, 3);
		run_circle('1, '1, '1, 2);
		run_circle(10'd512, 10'd512, 10'd1, 1000);
		run_circle(10'd341, 10'd682, 10'd5, 1000);
		send_item(CMD_NEXT, 10'h2AA, 10'h155, 10'h2AA);
		run_circle(10'h2AA, 10'h155, 10'h155, 2);
		run_circle(10'h155, 10'h2AA, 10'd2, 1000);

		while (sent_items < RANDOM_ITEMS) begin
			sel = int'($urandom_range(0, 99));
			if (sel < 72)
				r = COORD_BITS'($urandom_range(0, 24));
			else if (sel < 90)
				r = COORD_BITS'($urandom_range(25, 50));
			else
				r = COORD_BITS'($urandom);
			// big radii and some others get cut short by the next start
			max_next = (sel >= 90 || $urandom_range(0, 9) == 0) ?
				int'($urandom_range(0, 6)) : 1000;
			run_circle(COORD_BITS'($urandom), COORD_BITS'($urandom), r, max_next);
			if ($urandom_range(0, 3) == 0)
				send_item(CMD_NEXT, COORD_BITS'($urandom), COORD_BITS'($urandom),
					COORD_BITS'($urandom));
		end
		push <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending.size() != 0)
			sb.report_mismatch("expected points left over");
		if (sb.errors == 0)
			$display("midpoint_circle_points_unit: match");
		else
			$display("midpoint_circle_points_unit: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
src/mcp_pkg.sv
src/mcp_front.sv
src/mcp_queue.sv
src/mcp_back.sv
src/midpoint_circle_points_unit.sv
tb/midpoint_circle_points_unit_tb.sv
